// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; empty when synthesised.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TPCA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TPCA_ASSERT(lbl, prop, msg) \
  `TPCA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define TPCA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define TPCA_ASSERT(lbl, prop, msg)

`endif

`endif

// ----- hw/rtl/tpca_pkg.sv -----
package tpca_pkg;

  localparam int unsigned READ_W             = 22;
  localparam int unsigned MARGIN_W           = 10;
  localparam int unsigned AGREE_W            = 4;
  localparam int unsigned CFG_IDX_W          = 3;
  localparam int unsigned NUM_PADS           = 3;
  localparam int unsigned Q8_SHIFT           = 8;
  localparam int unsigned Q8_ONE             = 1 << Q8_SHIFT;
  localparam int unsigned WINDOW_SAMPLES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 8;
  localparam logic [READ_W-1:0]  MIN_FLOOR        = READ_W'(100);
  localparam logic [AGREE_W-1:0] AGREE_NEEDED_RST = AGREE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IDLE_LEFT    = 3'd0,
    REG_IDLE_CENTER  = 3'd1,
    REG_IDLE_RIGHT   = 3'd2,
    REG_FLOOR_LEFT   = 3'd3,
    REG_FLOOR_CENTER = 3'd4,
    REG_FLOOR_RIGHT  = 3'd5,
    REG_MARGIN_Q8    = 3'd6,
    REG_AGREE_NEEDED = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PAD_NONE   = 2'd0,
    PAD_LEFT   = 2'd1,
    PAD_CENTER = 2'd2,
    PAD_RIGHT  = 2'd3
  } pad_e;

  typedef struct packed {
    logic [NUM_PADS-1:0][READ_W-1:0] idle;
    logic [NUM_PADS-1:0][READ_W-1:0] floor_lvl;
    logic [MARGIN_W-1:0]             margin_q8;
    logic [AGREE_W-1:0]              agree_needed;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic              new_window;
    pad_e              sample_pad;
    logic [READ_W-1:0] best;
  } cand_t;

endpackage

// ----- hw/rtl/touch_pad_confirm_by_agreement_core.sv -----
// A request passes two classify stages, the queue write, then the output
// register before its result is valid.
// Throughput: one request per cycle while in_ready_o is high.
// in_ready_o drops only when QueueDepth requests are in flight.
// Reset (rst_ni low, asynchronous) clears the window, the queue, the credits
// and the valid flags; agree_needed returns to 2, the other settings to zero.
`include "assert_macros.svh"

module touch_pad_confirm_by_agreement_core import tpca_pkg::*; #(
  parameter int unsigned WindowSamples = WINDOW_SAMPLES_DEF,
  parameter int unsigned QueueDepth    = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 new_window_i,
  input  logic [READ_W-1:0]    reading_left_i,
  input  logic [READ_W-1:0]    reading_center_i,
  input  logic [READ_W-1:0]    reading_right_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 finished_o,
  output logic [1:0]           pad_o,
  output logic                 by_agreement_o,
  output logic [1:0]           sample_pad_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [READ_W-1:0]    cfg_data_i
);

  localparam int unsigned CredW = $clog2(QueueDepth + 1);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{idle: '0, floor_lvl: '0, margin_q8: '0, agree_needed: AGREE_NEEDED_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IDLE_LEFT:    cfg_q.idle[0]      <= cfg_data_i;
        REG_IDLE_CENTER:  cfg_q.idle[1]      <= cfg_data_i;
        REG_IDLE_RIGHT:   cfg_q.idle[2]      <= cfg_data_i;
        REG_FLOOR_LEFT:   cfg_q.floor_lvl[0] <= cfg_data_i;
        REG_FLOOR_CENTER: cfg_q.floor_lvl[1] <= cfg_data_i;
        REG_FLOOR_RIGHT:  cfg_q.floor_lvl[2] <= cfg_data_i;
        REG_MARGIN_Q8:    cfg_q.margin_q8    <= cfg_data_i[MARGIN_W-1:0];
        REG_AGREE_NEEDED: cfg_q.agree_needed <= cfg_data_i[AGREE_W-1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Credits cover the front stages and the queue, so the queue never overflows
  logic [CredW-1:0] credit_q, credit_d;
  logic             req, pop;

  assign in_ready_o = (credit_q < CredW'(QueueDepth));
  assign req        = in_valid_i && in_ready_o;

  always_comb begin
    credit_d = credit_q;
    if (req && !pop) begin
      credit_d = credit_q + 1'b1;
    end else if (!req && pop) begin
      credit_d = credit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  logic  front_valid, q_valid;
  cand_t front_cand, q_cand;

  tpca_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_i        (req),
    .new_window_i (new_window_i),
    .reading_i    ({reading_right_i, reading_center_i, reading_left_i}),
    .cand_valid_o (front_valid),
    .cand_o       (front_cand)
  );

  tpca_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cand),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_cand)
  );

  tpca_back #(
    .WindowSamples (WindowSamples)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .agree_needed_i (cfg_q.agree_needed),
    .cand_valid_i   (q_valid),
    .cand_i         (q_cand),
    .cand_pop_o     (pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .finished_o     (finished_o),
    .pad_o          (pad_o),
    .by_agreement_o (by_agreement_o),
    .sample_pad_o   (sample_pad_o)
  );

  `TPCA_ASSERT(a_idle_result_clean,
               out_valid_o && !finished_o |-> (pad_o == PAD_NONE) && !by_agreement_o,
               "unfinished result carries a decision")
  `TPCA_ASSERT(a_agree_matches_sample,
               out_valid_o && by_agreement_o |->
                 finished_o && (pad_o == sample_pad_o) && (pad_o != PAD_NONE),
               "agreement decision differs from sample pad")
  `TPCA_ASSERT(a_result_needs_credit,
               $rose(out_valid_o) |-> $past(credit_q) != '0,
               "result produced with no request in flight")

endmodule

// ----- hw/rtl/tpca_front.sv -----
module tpca_front import tpca_pkg::*; (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  cfg_t                            cfg_i,
  input  logic                            req_i,
  input  logic                            new_window_i,
  input  logic [NUM_PADS-1:0][READ_W-1:0] reading_i,
  output logic                            cand_valid_o,
  output cand_t                           cand_o
);

  localparam int unsigned ScaleW = MARGIN_W + 1;
  localparam int unsigned MulW   = READ_W + ScaleW;

  // Stage 1: deltas and qualification
  logic [NUM_PADS-1:0][READ_W:0]   diff;
  logic [NUM_PADS-1:0][READ_W-1:0] floor_eff;
  logic [NUM_PADS-1:0][READ_W-1:0] delta_d, delta_q;
  logic [NUM_PADS-1:0]             qual_d, qual_q;
  logic                            s1_valid_q, s1_nw_q;

  always_comb begin
    for (int i = 0; i < NUM_PADS; i++) begin
      diff[i]      = {1'b0, reading_i[i]} - {1'b0, cfg_i.idle[i]};
      delta_d[i]   = diff[i][READ_W] ? '0 : diff[i][READ_W-1:0];
      floor_eff[i] = (cfg_i.floor_lvl[i] == '0) ? MIN_FLOOR : cfg_i.floor_lvl[i];
      qual_d[i]    = (cfg_i.idle[i] != '0) && (delta_d[i] >= floor_eff[i]);
    end
  end

  // Stage 2: rank best and runner-up; on a tie the lower pad leads
  logic [READ_W-1:0] best_d, second_d, s2_best_q, s2_second_q;
  logic              hb_d, hs_d, s2_hb_q, s2_hs_q;
  pad_e              bidx_d, s2_bidx_q;
  logic              s2_valid_q, s2_nw_q;

  always_comb begin
    best_d   = '0;
    second_d = '0;
    hb_d     = 1'b0;
    hs_d     = 1'b0;
    bidx_d   = PAD_NONE;
    for (int i = 0; i < NUM_PADS; i++) begin
      if (qual_q[i]) begin
        if (!hb_d || delta_q[i] > best_d) begin
          if (hb_d) begin
            second_d = best_d;
            hs_d     = 1'b1;
          end
          best_d = delta_q[i];
          bidx_d = pad_e'(2'(i + 1));
          hb_d   = 1'b1;
        end else if (!hs_d || delta_q[i] > second_d) begin
          second_d = delta_q[i];
          hs_d     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i) begin
      s1_nw_q <= new_window_i;
      delta_q <= delta_d;
      qual_q  <= qual_d;
    end
    if (s1_valid_q) begin
      s2_nw_q     <= s1_nw_q;
      s2_best_q   <= best_d;
      s2_second_q <= second_d;
      s2_hb_q     <= hb_d;
      s2_hs_q     <= hs_d;
      s2_bidx_q   <= bidx_d;
    end
  end

  // Stage 3: margin check best*256 >= second*(256+margin), written to the queue
  logic [ScaleW-1:0] scale;
  logic [MulW-1:0]   prod, lhs;
  logic              margin_ok;

  always_comb begin
    scale     = {1'b0, cfg_i.margin_q8} + ScaleW'(Q8_ONE);
    prod      = MulW'(s2_second_q) * MulW'(scale);
    lhs       = MulW'({s2_best_q, {Q8_SHIFT{1'b0}}});
    margin_ok = (cfg_i.margin_q8 == '0) || !s2_hs_q || (lhs >= prod);
  end

  assign cand_valid_o      = s2_valid_q;
  assign cand_o.new_window = s2_nw_q;
  assign cand_o.sample_pad = (s2_hb_q && margin_ok) ? s2_bidx_q : PAD_NONE;
  assign cand_o.best       = s2_best_q;

endmodule

// ----- hw/rtl/tpca_queue.sv -----
module tpca_queue import tpca_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cand_t data_i,
  input  logic  pop_i,
  output logic  valid_o,
  output cand_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cand_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

// ----- hw/rtl/tpca_back.sv -----
module tpca_back import tpca_pkg::*; #(
  parameter int unsigned WindowSamples = WINDOW_SAMPLES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [AGREE_W-1:0] agree_needed_i,
  input  logic               cand_valid_i,
  input  cand_t              cand_i,
  output logic               cand_pop_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               finished_o,
  output logic [1:0]         pad_o,
  output logic               by_agreement_o,
  output logic [1:0]         sample_pad_o
);

  localparam int unsigned CntW = $clog2(WindowSamples + 1);

  logic [CntW-1:0]    sample_cnt_q, sample_cnt_d;
  pad_e               agree_pad_q, agree_pad_d;
  logic [AGREE_W-1:0] agree_cnt_q, agree_cnt_d;
  pad_e               best_pad_q, best_pad_d;
  logic [READ_W-1:0]  best_delta_q, best_delta_d;
  logic               best_valid_q, best_valid_d;

  logic               out_valid_q, out_valid_d;
  logic               finished_q, by_agreement_q;
  pad_e               pad_q, sample_pad_q;

  logic               fin;
  logic               by_agr;
  pad_e               dec_pad;
  logic               pop;

  assign pop = cand_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    sample_cnt_d = sample_cnt_q;
    agree_pad_d  = agree_pad_q;
    agree_cnt_d  = agree_cnt_q;
    best_pad_d   = best_pad_q;
    best_delta_d = best_delta_q;
    best_valid_d = best_valid_q;
    fin          = 1'b0;
    by_agr       = 1'b0;
    dec_pad      = PAD_NONE;

    if (cand_i.new_window) begin
      sample_cnt_d = '0;
      agree_pad_d  = PAD_NONE;
      agree_cnt_d  = '0;
      best_pad_d   = PAD_NONE;
      best_delta_d = '0;
      best_valid_d = 1'b0;
    end

    if (cand_i.sample_pad != PAD_NONE) begin
      if (cand_i.sample_pad == agree_pad_d) begin
        if (agree_cnt_d != '1) begin
          agree_cnt_d = agree_cnt_d + 1'b1;
        end
      end else begin
        agree_pad_d = cand_i.sample_pad;
        agree_cnt_d = AGREE_W'(1);
      end
      if (!best_valid_d || cand_i.best > best_delta_d) begin
        best_delta_d = cand_i.best;
        best_pad_d   = cand_i.sample_pad;
        best_valid_d = 1'b1;
      end
      if (agree_cnt_d >= agree_needed_i) begin
        fin     = 1'b1;
        by_agr  = 1'b1;
        dec_pad = agree_pad_d;
      end
    end else begin
      agree_pad_d = PAD_NONE;
      agree_cnt_d = '0;
    end

    // Window end; the count never passes the window length
    if (!fin) begin
      sample_cnt_d = sample_cnt_d + 1'b1;
      if (sample_cnt_d == CntW'(WindowSamples)) begin
        fin     = 1'b1;
        dec_pad = best_valid_d ? best_pad_d : PAD_NONE;
      end
    end

    if (fin) begin
      sample_cnt_d = '0;
      agree_pad_d  = PAD_NONE;
      agree_cnt_d  = '0;
      best_pad_d   = PAD_NONE;
      best_delta_d = '0;
      best_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_cnt_q <= '0;
      agree_pad_q  <= PAD_NONE;
      agree_cnt_q  <= '0;
      best_pad_q   <= PAD_NONE;
      best_delta_q <= '0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        sample_cnt_q <= sample_cnt_d;
        agree_pad_q  <= agree_pad_d;
        agree_cnt_q  <= agree_cnt_d;
        best_pad_q   <= best_pad_d;
        best_delta_q <= best_delta_d;
        best_valid_q <= best_valid_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      finished_q     <= fin;
      pad_q          <= dec_pad;
      by_agreement_q <= by_agr;
      sample_pad_q   <= cand_i.sample_pad;
    end
  end

  assign cand_pop_o     = pop;
  assign out_valid_o    = out_valid_q;
  assign finished_o     = finished_q;
  assign pad_o          = pad_q;
  assign by_agreement_o = by_agreement_q;
  assign sample_pad_o   = sample_pad_q;

endmodule

// ----- bench/touch_pad_confirm_by_agreement_core_tb.sv -----
module touch_pad_confirm_by_agreement_core_tb;
  import tpca_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_REQS = 200;
  localparam logic [READ_W-1:0] READ_MAX = '1;

  typedef struct packed {
    logic finished;
    pad_e pad;
    logic by_agreement;
    pad_e sample_pad;
  } decision_t;

  typedef struct {
    bit is_cfg;
    cfg_reg_e reg_sel;
    logic [READ_W-1:0] value;
    logic nw;
    logic [READ_W-1:0] rd_l;
    logic [READ_W-1:0] rd_c;
    logic [READ_W-1:0] rd_r;
    bit typed;
    decision_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic nw_d = 1'b0;
  logic [READ_W-1:0] rl_d = '0;
  logic [READ_W-1:0] rc_d = '0;
  logic [READ_W-1:0] rr_d = '0;
  logic out_valid;
  logic res_ready = 1'b0;
  logic finished;
  logic [1:0] pad;
  logic by_agreement;
  logic [1:0] sample_pad;
  logic cfg_we = 1'b0;
  cfg_reg_e cfg_idx = REG_IDLE_LEFT;
  logic [READ_W-1:0] cfg_data = '0;

  // register mirror
  logic [READ_W-1:0] idle_v [NUM_PADS];
  logic [READ_W-1:0] floor_v [NUM_PADS];
  logic [MARGIN_W-1:0] margin_v;
  logic [AGREE_W-1:0] agree_v;

  // window state of the predictor
  int win_count;
  pad_e run_pad;
  logic [AGREE_W-1:0] run_len;
  pad_e peak_pad;
  logic [READ_W-1:0] peak_delta;
  bit peak_valid;

  decision_t pending_decisions[$];
  stim_row_t script[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idling_on = 1'b1;

  always #1 clk = ~clk;

  touch_pad_confirm_by_agreement_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .new_window_i     (nw_d),
    .reading_left_i   (rl_d),
    .reading_center_i (rc_d),
    .reading_right_i  (rr_d),
    .out_valid_o      (out_valid),
    .out_ready_i      (res_ready),
    .finished_o       (finished),
    .pad_o            (pad),
    .by_agreement_o   (by_agreement),
    .sample_pad_o     (sample_pad),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  function automatic logic [READ_W-1:0] floor_eff(int i);
    return (floor_v[i] != '0) ? floor_v[i] : MIN_FLOOR;
  endfunction

  function void open_window();
    win_count = 0;
    run_pad = PAD_NONE;
    run_len = '0;
    peak_pad = PAD_NONE;
    peak_delta = '0;
    peak_valid = 1'b0;
  endfunction

  function void reset_mirror();
    for (int i = 0; i < NUM_PADS; i++) begin
      idle_v[i] = '0;
      floor_v[i] = '0;
    end
    margin_v = '0;
    agree_v = AGREE_NEEDED_RST;
    open_window();
  endfunction

  task automatic decide_touch(input logic nw, input logic [READ_W-1:0] rl, rc, rr,
                              output decision_t d);
    logic [READ_W-1:0] rd [NUM_PADS];
    logic [READ_W-1:0] delta;
    logic [READ_W-1:0] best;
    logic [READ_W-1:0] second;
    bit have_best;
    bit have_second;
    bit ok;
    int best_i;
    rd[0] = rl;
    rd[1] = rc;
    rd[2] = rr;
    best = '0;
    second = '0;
    have_best = 1'b0;
    have_second = 1'b0;
    best_i = 0;
    d = '0;
    if (nw) open_window();
    for (int i = 0; i < NUM_PADS; i++) begin
      if (idle_v[i] == '0) continue;
      delta = (rd[i] > idle_v[i]) ? rd[i] - idle_v[i] : '0;
      if (delta < floor_eff(i)) continue;
      // equal deltas: the lower pad keeps the lead, the newcomer is runner-up
      if (!have_best || delta > best) begin
        if (have_best) begin
          second = best;
          have_second = 1'b1;
        end
        best = delta;
        best_i = i;
        have_best = 1'b1;
      end else if (!have_second || delta > second) begin
        second = delta;
        have_second = 1'b1;
      end
    end
    ok = have_best && (margin_v == '0 || !have_second ||
         longint'(best) * Q8_ONE >= longint'(second) * (Q8_ONE + margin_v));
    d.sample_pad = ok ? pad_e'(2'(best_i + 1)) : PAD_NONE;
    if (d.sample_pad != PAD_NONE) begin
      if (d.sample_pad == run_pad) begin
        if (run_len != 4'd15) run_len++;
      end else begin
        run_pad = d.sample_pad;
        run_len = 4'd1;
      end
      if (!peak_valid || best > peak_delta) begin
        peak_delta = best;
        peak_pad = d.sample_pad;
        peak_valid = 1'b1;
      end
      if (run_len >= agree_v) begin
        d.finished = 1'b1;
        d.pad = run_pad;
        d.by_agreement = 1'b1;
      end
    end else begin
      run_pad = PAD_NONE;
      run_len = '0;
    end
    // window end only when agreement has not already decided
    if (!d.finished) begin
      win_count++;
      if (win_count >= WINDOW_SAMPLES_DEF) begin
        d.finished = 1'b1;
        d.pad = peak_valid ? peak_pad : PAD_NONE;
      end
    end
    if (d.finished) open_window();
  endtask

  task automatic add_cfg(cfg_reg_e r, logic [READ_W-1:0] v);
    stim_row_t row;
    row.is_cfg = 1'b1;
    row.reg_sel = r;
    row.value = v;
    script.push_back(row);
  endtask

  task automatic add_req(logic nw, logic [READ_W-1:0] l, c, r);
    stim_row_t row;
    row.is_cfg = 1'b0;
    row.nw = nw;
    row.rd_l = l;
    row.rd_c = c;
    row.rd_r = r;
    row.typed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endtask

  task automatic add_known(logic nw, logic [READ_W-1:0] l, c, r,
                           logic fin, pad_e p, logic ba, pad_e sp);
    add_req(nw, l, c, r);
    script[script.size()-1].typed = 1'b1;
    script[script.size()-1].want = '{finished: fin, pad: p, by_agreement: ba, sample_pad: sp};
  endtask

  task automatic write_reg(cfg_reg_e r, logic [READ_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_data <= v;
    case (r)
      REG_IDLE_LEFT:    idle_v[0] = v;
      REG_IDLE_CENTER:  idle_v[1] = v;
      REG_IDLE_RIGHT:   idle_v[2] = v;
      REG_FLOOR_LEFT:   floor_v[0] = v;
      REG_FLOOR_CENTER: floor_v[1] = v;
      REG_FLOOR_RIGHT:  floor_v[2] = v;
      REG_MARGIN_Q8:    margin_v = v[MARGIN_W-1:0];
      REG_AGREE_NEEDED: agree_v = v[AGREE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold the sender until every outstanding request has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic issue(logic nw, logic [READ_W-1:0] l, c, r, bit typed, decision_t known);
    decision_t d;
    in_valid <= 1'b1;
    nw_d <= nw;
    rl_d <= l;
    rc_d <= c;
    rr_d <= r;
    do @(posedge clk); while (!in_ready);
    decide_touch(nw, l, c, r, d);
    pending_decisions.push_back(typed ? known : d);
  endtask

  function automatic logic [READ_W-1:0] above_idle(logic [READ_W-1:0] idle,
                                                   longint unsigned d);
    longint unsigned s;
    s = longint'(idle) + d;
    return (s > READ_MAX) ? READ_MAX : s[READ_W-1:0];
  endfunction

  function automatic logic [READ_W-1:0] pick_idle();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return READ_MAX;
      2: return READ_W'(1);
      default: return READ_W'($urandom_range(500, 3000000));
    endcase
  endfunction

  function automatic logic [READ_W-1:0] pick_floor();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3: return READ_MAX;
      4: return READ_W'(1);
      default: return READ_W'($urandom_range(1, 5000));
    endcase
  endfunction

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst_n && out_valid && res_ready) begin
      if (pending_decisions.size() == 0) begin
        $error("decision: expected none, actual %0d", finished);
        mismatches++;
      end else begin
        want = pending_decisions.pop_front();
        check_field("finished", 2'(want.finished), 2'(finished));
        check_field("pad", want.pad, pad);
        check_field("by_agreement", 2'(want.by_agreement), 2'(by_agreement));
        check_field("sample_pad", want.sample_pad, sample_pad);
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_ready <= (stall_left == 1);
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 18);
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && res_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [READ_W-1:0] vals [8];
    logic [READ_W-1:0] rd [NUM_PADS];
    longint unsigned fav_delta;
    longint unsigned dl;
    pad_e fav;
    int last;
    reset_mirror();
    fav = PAD_NONE;

    // reset values: every pad disabled, so the window runs out empty
    add_known(1'b1, READ_MAX, READ_MAX, READ_MAX, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, 22'h155555, 22'h2AAAAA, 22'h155555, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, 22'h2AAAAA, 22'h155555, 22'h2AAAAA, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, '0, '0, '0, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, 22'd1000, 22'd1000, 22'd1000, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, 22'h0F0F0F, 22'h30F0F0, 22'h3C3C3C, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, '0, READ_MAX, '0, 1'b0, PAD_NONE, 1'b0, PAD_NONE);
    add_known(1'b0, '0, '0, '0, 1'b1, PAD_NONE, 1'b0, PAD_NONE);

    // built-in floor, agreement of two
    add_cfg(REG_IDLE_LEFT, 22'd1000);
    add_cfg(REG_IDLE_CENTER, 22'd1000);
    add_cfg(REG_IDLE_RIGHT, 22'd1000);
    add_known(1'b1, 22'd1100, '0, '0, 1'b0, PAD_NONE, 1'b0, PAD_LEFT);
    add_known(1'b0, 22'd1100, '0, '0, 1'b1, PAD_LEFT, 1'b1, PAD_LEFT);
    add_req(1'b0, 22'd1500, 22'd1500, '0);
    add_req(1'b0, 22'd1099, 22'd1200, 22'd1300);

    // widest margin, tie without winner, single qualifier
    add_cfg(REG_MARGIN_Q8, 22'd1023);
    add_cfg(REG_AGREE_NEEDED, 22'd15);
    add_cfg(REG_FLOOR_CENTER, 22'd1);
    add_cfg(REG_IDLE_RIGHT, READ_MAX);
    add_req(1'b1, 22'd1500, 22'd1500, '0);
    add_req(1'b0, READ_MAX, 22'd1200, '0);
    add_req(1'b0, '0, 22'd1001, READ_MAX);

    // zero agreement count decides on the first winner
    add_cfg(REG_MARGIN_Q8, 22'd0);
    add_cfg(REG_AGREE_NEEDED, 22'd0);
    add_cfg(REG_IDLE_LEFT, 22'd0);
    add_cfg(REG_IDLE_RIGHT, 22'd1000);
    add_cfg(REG_FLOOR_RIGHT, 22'd200);
    add_known(1'b1, READ_MAX, '0, 22'd1200, 1'b1, PAD_RIGHT, 1'b1, PAD_RIGHT);
    add_known(1'b0, '0, 22'd1001, 22'd1100, 1'b1, PAD_CENTER, 1'b1, PAD_CENTER);

    // agreement lands on the last sample of the window and wins over window end
    add_cfg(REG_AGREE_NEEDED, 22'd2);
    add_cfg(REG_IDLE_LEFT, 22'd1000);
    add_cfg(REG_FLOOR_RIGHT, 22'd0);
    for (int k = 0; k < 7; k++) begin
      if (k % 2 == 0) add_req(1'b0, '0, READ_W'(1300 + k), '0);
      else add_req(1'b0, '0, '0, READ_W'(1300 + k));
    end
    add_known(1'b0, '0, 22'd1300, '0, 1'b1, PAD_CENTER, 1'b1, PAD_CENTER);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    last = script.size() - 1;
    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        if (k == 0 || !script[k-1].is_cfg) wait_drained();
        write_reg(script[k].reg_sel, script[k].value);
        if (k == last || !script[k+1].is_cfg) cfg_we <= 1'b0;
      end else begin
        maybe_gap();
        issue(script[k].nw, script[k].rd_l, script[k].rd_c, script[k].rd_r,
              script[k].typed, script[k].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      idling_on = (ph != NUM_PHASES - 1) && (ph % 4 != 2);
      for (int i = 0; i < NUM_PADS; i++) begin
        vals[i] = pick_idle();
        vals[i + 3] = pick_floor();
      end
      case ($urandom_range(0, 7))
        0, 1: vals[6] = '0;
        2: vals[6] = READ_W'(1023);
        default: vals[6] = READ_W'($urandom_range(1, 1023));
      endcase
      case ($urandom_range(0, 7))
        0: vals[7] = '0;
        1: vals[7] = READ_W'(15);
        default: vals[7] = READ_W'($urandom_range(1, 4));
      endcase
      if (ph == 0) begin
        vals[6] = READ_W'(1023);
        vals[7] = READ_W'(1);
      end else if (ph == 1) begin
        // agreement out of reach: a window is decided only on its sample count
        vals[6] = '0;
        vals[7] = READ_W'(15);
      end
      // unused upper bits of the narrow registers carry noise
      vals[6][READ_W-1:MARGIN_W] = (READ_W - MARGIN_W)'($urandom);
      vals[7][READ_W-1:AGREE_W] = (READ_W - AGREE_W)'($urandom);
      for (int r = 0; r < 8; r++) write_reg(cfg_reg_e'(CFG_IDX_W'(r)), vals[r]);
      cfg_we <= 1'b0;

      for (int n = 0; n < PHASE_REQS; n++) begin
        if ($urandom_range(0, 3) == 0) fav = pad_e'(2'($urandom_range(0, 3)));
        fav_delta = 0;
        if (fav != PAD_NONE) begin
          fav_delta = floor_eff(int'(fav) - 1);
          fav_delta += ($urandom_range(0, 3) == 0) ? $urandom_range(0, 'h3FFFFF)
                                                   : $urandom_range(0, 4000);
        end
        for (int p = 0; p < NUM_PADS; p++) begin
          if ($urandom_range(0, 11) == 0) begin
            rd[p] = READ_W'($urandom);
          end else begin
            if (fav != PAD_NONE && p == int'(fav) - 1) begin
              dl = fav_delta;
            end else begin
              case ($urandom_range(0, 3))
                0: dl = 0;
                1: dl = $urandom_range(0, 32'(floor_eff(p)) * 2);
                2: dl = fav_delta;
                default: dl = fav_delta / 2;
              endcase
            end
            rd[p] = (dl == 0) ? READ_W'($urandom_range(0, idle_v[p]))
                              : above_idle(idle_v[p], dl);
          end
        end
        maybe_gap();
        issue($urandom_range(0, 15) == 0, rd[0], rd[1], rd[2], 1'b0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
